/* rtl/json_pair_tokenizer_assert.svh */
`ifndef JSON_PAIR_TOKENIZER_ASSERT_SVH
`define JSON_PAIR_TOKENIZER_ASSERT_SVH

// Same-cycle implication check
`define JPT_ASSERT_NOW(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("json_pair_tokenizer: same-cycle check failed");

// Next-cycle implication check
`define JPT_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("json_pair_tokenizer: next-cycle check failed");

`endif

/* rtl/jpt_pkg.sv */
package jpt_pkg;

    localparam int JPT_NUMBER_BITS = 31;

    typedef enum logic [2:0] {
        PH_QUOTE  = 3'd0,
        PH_KEY    = 3'd1,
        PH_COLON  = 3'd2,
        PH_VALUE  = 3'd3,
        PH_NUMBER = 3'd4,
        PH_STRING = 3'd5,
        PH_ESCAPE = 3'd6,
        PH_ERROR  = 3'd7
    } phase_t;

    typedef enum logic [2:0] {
        TK_KEY_CHAR   = 3'd0,
        TK_VALUE_CHAR = 3'd1,
        TK_KEY_END    = 3'd2,
        TK_NUMBER     = 3'd3,
        TK_STRING_END = 3'd4,
        TK_NO_QUOTE   = 3'd5,
        TK_NO_COLON   = 3'd6
    } token_kind_t;

    // Per-byte decision of the step logic; the numeric payload travels beside it
    typedef struct packed {
        logic [1:0]  n_res;
        token_kind_t kind0;
        token_kind_t kind1;
        logic [7:0]  char0;
        phase_t      phase_next;
    } step_ctl_t;

endpackage

/* rtl/jpt_step.sv */
module jpt_step #(
    parameter int NUMBER_BITS = jpt_pkg::JPT_NUMBER_BITS
) (
    input  jpt_pkg::phase_t          phase,
    input  logic [NUMBER_BITS-1:0]   acc,
    input  logic                     sat,
    input  logic [7:0]               byte_in,
    output jpt_pkg::step_ctl_t       ctl,
    output logic [NUMBER_BITS-1:0]   acc_next,
    output logic                     sat_next,
    output logic [NUMBER_BITS-1:0]   num_out,
    output logic                     ovf_out
);

    localparam int PW = NUMBER_BITS + 4;
    localparam logic [PW-1:0] NUM_MAX_W = {4'b0000, {NUMBER_BITS{1'b1}}};

    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_COLON     = 8'h3A;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_ZERO      = 8'h30;
    localparam logic [7:0] CH_NINE      = 8'h39;

    logic          is_space;
    logic          is_digit;
    logic [3:0]    digit;
    logic [PW-1:0] acc_w;
    logic [PW-1:0] prod;
    logic          esc_valid;
    logic [7:0]    esc_char;

    assign is_space = (byte_in == 8'h20) || (byte_in >= 8'h09 && byte_in <= 8'h0D);
    assign is_digit = (byte_in >= CH_ZERO) && (byte_in <= CH_NINE);
    assign digit    = 4'(byte_in - CH_ZERO);
    assign acc_w    = PW'(acc);
    // acc * 10 + digit by shift and add
    assign prod     = (acc_w << 3) + (acc_w << 1) + PW'(digit);

    always_comb
    begin
        esc_valid = 1'b1;
        esc_char  = 8'h00;
        unique case (byte_in)
            8'h6E: esc_char = 8'h0A;   // n
            8'h74: esc_char = 8'h09;   // t
            8'h76: esc_char = 8'h0B;   // v
            8'h62: esc_char = 8'h08;   // b
            8'h72: esc_char = 8'h0D;   // r
            8'h66: esc_char = 8'h0C;   // f
            8'h61: esc_char = 8'h07;   // a
            8'h3F: esc_char = 8'h3F;   // ?
            8'h27: esc_char = 8'h27;   // '
            8'h22: esc_char = 8'h22;   // "
            8'h30: esc_char = 8'h00;   // 0
            default: esc_valid = 1'b0; // u, U and unknown escapes are dropped
        endcase
    end

    always_comb
    begin
        ctl.n_res      = 2'd0;
        ctl.kind0      = jpt_pkg::TK_KEY_CHAR;
        ctl.kind1      = jpt_pkg::TK_NO_QUOTE;
        ctl.char0      = 8'h00;
        ctl.phase_next = phase;
        acc_next       = acc;
        sat_next       = sat;
        num_out        = '0;
        ovf_out        = 1'b0;

        unique case (phase)
            jpt_pkg::PH_QUOTE:
            begin
                if (!is_space)
                begin
                    if (byte_in == CH_QUOTE)
                    begin
                        ctl.phase_next = jpt_pkg::PH_KEY;
                    end
                    else
                    begin
                        ctl.n_res      = 2'd1;
                        ctl.kind0      = jpt_pkg::TK_NO_QUOTE;
                        ctl.phase_next = jpt_pkg::PH_ERROR;
                        acc_next       = '0;
                        sat_next       = 1'b0;
                    end
                end
            end
            jpt_pkg::PH_KEY:
            begin
                if (!is_space)
                begin
                    ctl.n_res = 2'd1;
                    if (byte_in == CH_QUOTE)
                    begin
                        ctl.kind0      = jpt_pkg::TK_KEY_END;
                        ctl.phase_next = jpt_pkg::PH_COLON;
                    end
                    else
                    begin
                        ctl.kind0 = jpt_pkg::TK_KEY_CHAR;
                        ctl.char0 = byte_in;
                    end
                end
            end
            jpt_pkg::PH_COLON:
            begin
                if (!is_space)
                begin
                    if (byte_in == CH_COLON)
                    begin
                        ctl.phase_next = jpt_pkg::PH_VALUE;
                    end
                    else
                    begin
                        ctl.n_res      = 2'd1;
                        ctl.kind0      = jpt_pkg::TK_NO_COLON;
                        ctl.phase_next = jpt_pkg::PH_ERROR;
                        acc_next       = '0;
                        sat_next       = 1'b1;
                    end
                end
            end
            jpt_pkg::PH_VALUE:
            begin
                if (!is_space)
                begin
                    if (is_digit)
                    begin
                        acc_next       = NUMBER_BITS'(digit);
                        sat_next       = 1'b0;
                        ctl.phase_next = jpt_pkg::PH_NUMBER;
                    end
                    else
                    begin
                        ctl.phase_next = jpt_pkg::PH_STRING;
                    end
                end
            end
            jpt_pkg::PH_NUMBER:
            begin
                if (is_digit)
                begin
                    if (sat || prod > NUM_MAX_W)
                    begin
                        acc_next = {NUMBER_BITS{1'b1}};
                        sat_next = 1'b1;
                    end
                    else
                    begin
                        acc_next = prod[NUMBER_BITS-1:0];
                    end
                end
                else
                begin
                    // Number token, then the same byte opens the next pair
                    ctl.n_res      = 2'd1;
                    ctl.kind0      = jpt_pkg::TK_NUMBER;
                    num_out        = acc;
                    ovf_out        = sat;
                    acc_next       = '0;
                    sat_next       = 1'b0;
                    ctl.phase_next = jpt_pkg::PH_QUOTE;
                    if (!is_space)
                    begin
                        if (byte_in == CH_QUOTE)
                        begin
                            ctl.phase_next = jpt_pkg::PH_KEY;
                        end
                        else
                        begin
                            ctl.n_res      = 2'd2;
                            ctl.kind1      = jpt_pkg::TK_NO_QUOTE;
                            ctl.phase_next = jpt_pkg::PH_ERROR;
                        end
                    end
                end
            end
            jpt_pkg::PH_STRING:
            begin
                if (byte_in == CH_BACKSLASH)
                begin
                    ctl.phase_next = jpt_pkg::PH_ESCAPE;
                end
                else if (byte_in == CH_QUOTE)
                begin
                    ctl.n_res      = 2'd1;
                    ctl.kind0      = jpt_pkg::TK_STRING_END;
                    ctl.phase_next = jpt_pkg::PH_QUOTE;
                end
                else
                begin
                    ctl.n_res = 2'd1;
                    ctl.kind0 = jpt_pkg::TK_VALUE_CHAR;
                    ctl.char0 = byte_in;
                end
            end
            jpt_pkg::PH_ESCAPE:
            begin
                if (esc_valid)
                begin
                    ctl.n_res = 2'd1;
                    ctl.kind0 = jpt_pkg::TK_VALUE_CHAR;
                    ctl.char0 = esc_char;
                end
                ctl.phase_next = jpt_pkg::PH_STRING;
            end
            jpt_pkg::PH_ERROR:
            begin
                // sat holds the error kind while stuck here
                ctl.n_res = 2'd1;
                ctl.kind0 = sat ? jpt_pkg::TK_NO_COLON : jpt_pkg::TK_NO_QUOTE;
            end
            default:
            begin
                ctl.n_res = 2'd0;
            end
        endcase
    end

endmodule

/* rtl/json_pair_tokenizer.sv */
// Tokenizer for a byte stream of "key":value pairs. One byte is taken per cycle on the
// s_axis side; results leave on m_axis with the token kind in tuser and tlast marking the
// final result caused by a byte. A byte is first held in the input register; once the queue
// has room for two results, its state update and results are written into a four-entry
// result queue, from whose head the first result can leave.
// Throughput is one byte per cycle as long as the sink keeps up. A number ended by a byte
// that is neither whitespace nor a quote gives two results; the queue absorbs the extra one,
// so s_axis only stalls while the sink holds off and the queue has fewer than two free slots.
// After a missing quote or colon every further byte returns the same error until reset.
module json_pair_tokenizer #(
    parameter int NUMBER_BITS = jpt_pkg::JPT_NUMBER_BITS,
    localparam int OUT_BITS   = ((8 + NUMBER_BITS + 1 + 7) / 8) * 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [7:0]          s_axis_tdata,   // [7:0] byte_in
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [OUT_BITS-1:0] m_axis_tdata,   // char_out, number_out, overflow, zero pad
    output logic [2:0]          m_axis_tuser,   // token_kind
    output logic                m_axis_tlast    // last
);

`include "json_pair_tokenizer_assert.svh"

    localparam int DEPTH = 4;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] ROOM_LIMIT = CNT_W'(DEPTH - 2);
    localparam int PAD_BITS = OUT_BITS - (8 + NUMBER_BITS + 1);

    logic                   in_valid_reg;
    logic [7:0]             in_byte_reg;

    jpt_pkg::phase_t        phase_reg;
    logic [NUMBER_BITS-1:0] acc_reg;
    logic                   sat_reg;

    jpt_pkg::step_ctl_t     ctl;
    logic [NUMBER_BITS-1:0] acc_next;
    logic                   sat_next;
    logic [NUMBER_BITS-1:0] num_out;
    logic                   ovf_out;

    jpt_pkg::token_kind_t   q_kind_reg [DEPTH];
    logic [7:0]             q_char_reg [DEPTH];
    logic [NUMBER_BITS-1:0] q_num_reg  [DEPTH];
    logic                   q_ovf_reg  [DEPTH];
    logic                   q_last_reg [DEPTH];
    logic [PTR_W-1:0]       wr_ptr_reg;
    logic [PTR_W-1:0]       rd_ptr_reg;
    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       count_next;

    logic                   fire;
    logic                   pop;
    logic [1:0]             n_push;

    jpt_step #(
        .NUMBER_BITS (NUMBER_BITS)
    ) u_step (
        .phase    (phase_reg),
        .acc      (acc_reg),
        .sat      (sat_reg),
        .byte_in  (in_byte_reg),
        .ctl      (ctl),
        .acc_next (acc_next),
        .sat_next (sat_next),
        .num_out  (num_out),
        .ovf_out  (ovf_out)
    );

    // Process the held byte only when the queue can take two results
    assign fire          = in_valid_reg && (count_reg <= ROOM_LIMIT);
    assign s_axis_tready = !in_valid_reg || fire;
    assign pop           = m_axis_tvalid && m_axis_tready;
    assign n_push        = fire ? ctl.n_res : 2'd0;
    assign count_next    = count_reg + CNT_W'(n_push) - CNT_W'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tvalid && s_axis_tready)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (fire)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_byte_reg <= s_axis_tdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= jpt_pkg::PH_QUOTE;
            acc_reg   <= '0;
            sat_reg   <= 1'b0;
        end
        else if (fire)
        begin
            phase_reg <= ctl.phase_next;
            acc_reg   <= acc_next;
            sat_reg   <= sat_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + PTR_W'(n_push);
            rd_ptr_reg <= rd_ptr_reg + PTR_W'(pop);
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (n_push != 2'd0)
        begin
            q_kind_reg[wr_ptr_reg] <= ctl.kind0;
            q_char_reg[wr_ptr_reg] <= ctl.char0;
            q_num_reg[wr_ptr_reg]  <= num_out;
            q_ovf_reg[wr_ptr_reg]  <= ovf_out;
            q_last_reg[wr_ptr_reg] <= (n_push == 2'd1);
        end
        if (n_push == 2'd2)
        begin
            q_kind_reg[wr_ptr_reg + PTR_W'(1)] <= ctl.kind1;
            q_char_reg[wr_ptr_reg + PTR_W'(1)] <= 8'h00;
            q_num_reg[wr_ptr_reg + PTR_W'(1)]  <= '0;
            q_ovf_reg[wr_ptr_reg + PTR_W'(1)]  <= 1'b0;
            q_last_reg[wr_ptr_reg + PTR_W'(1)] <= 1'b1;
        end
    end

    assign m_axis_tvalid = (count_reg != '0);
    assign m_axis_tuser  = q_kind_reg[rd_ptr_reg];
    assign m_axis_tlast  = q_last_reg[rd_ptr_reg];
    assign m_axis_tdata  = {{PAD_BITS{1'b0}}, q_ovf_reg[rd_ptr_reg],
                            q_num_reg[rd_ptr_reg], q_char_reg[rd_ptr_reg]};

    `JPT_ASSERT_NOW(a_queue_bound, clk, rst_n, 1'b1, count_reg <= CNT_W'(DEPTH))
    `JPT_ASSERT_NOW(a_error_one_result, clk, rst_n,
        fire && phase_reg == jpt_pkg::PH_ERROR, ctl.n_res == 2'd1)
    `JPT_ASSERT_NEXT(a_error_sticky, clk, rst_n,
        phase_reg == jpt_pkg::PH_ERROR, phase_reg == jpt_pkg::PH_ERROR)
    `JPT_ASSERT_NOW(a_saturated_at_max, clk, rst_n,
        phase_reg == jpt_pkg::PH_NUMBER && sat_reg, acc_reg == {NUMBER_BITS{1'b1}})

endmodule
